// File: rtl/dwl_pkg.sv
// dwl_pkg: shared types, constants and helpers for the word graph lookup.
// Used by dwl_node_ram, dwl_walker and dawg_word_lookup; no dependencies.
package dwl_pkg;

	localparam int NODE_DEPTH = 65536;
	localparam int ADDR_W     = $clog2(NODE_DEPTH);
	localparam int NODE_W     = 23;
	localparam int CHILD_W    = 16;
	localparam int TOTAL_W    = 17;
	localparam int MAX_HOOKS  = 32;
	localparam int HCNT_W     = $clog2(MAX_HOOKS + 1);
	localparam int CFG_IDX_W  = 1;

	localparam logic [7:0] ROOT_MIN   = 8'd26;
	localparam logic [4:0] LAST_ALPHA = 5'd25;
	localparam logic [4:0] LAST_DIGIT = 5'd29;
	localparam logic [7:0] DIGIT_BIAS = 8'd23;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic RES_VERDICT = 1'b0;
	localparam logic RES_HOOK    = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_NODE_TOTAL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOOKS_EN   = 1'd1;

	typedef struct packed {
		logic        req_type;
		logic [15:0] node_addr;
		logic [31:0] node_word;
		logic [7:0]  query_char;
		logic        query_last;
	} req_t;

	typedef struct packed {
		logic        result_kind;
		logic        word_found;
		logic        prefix_found;
		logic [15:0] end_node;
		logic [7:0]  hook_char;
		logic        last_result;
	} rsp_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] node_total;
		logic               hooks_enable;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHILD,
		ST_CMP,
		ST_AFTER,
		ST_HOOK,
		ST_FLUSH
	} state_t;

	// 5-bit letter code to ASCII; codes 30 and 31 decode to no letter (0)
	function automatic logic [7:0] node_letter(input logic [4:0] code);
		logic [7:0] l;
		if (code <= LAST_ALPHA)
			l = 8'("A") + {3'd0, code};
		else if (code <= LAST_DIGIT)
			l = {3'd0, code} + DIGIT_BIAS;
		else
			l = 8'd0;
		return l;
	endfunction

	function automatic logic [7:0] fold_upper(input logic [7:0] c);
		logic [7:0] u;
		if (c >= 8'("a") && c <= 8'("z"))
			u = c - 8'd32;
		else
			u = c;
		return u;
	endfunction

endpackage

// File: rtl/dwl_node_ram.sv
// dwl_node_ram: node store, one write port and one read port, read data registered.
// Depends on dwl_pkg for depth and word width.
module dwl_node_ram (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [dwl_pkg::ADDR_W-1:0]  wr_addr,
	input  logic [dwl_pkg::NODE_W-1:0]  wr_data,
	input  logic                        rd_en,
	input  logic [dwl_pkg::ADDR_W-1:0]  rd_addr,
	output logic [dwl_pkg::NODE_W-1:0]  rd_data
);

	logic [dwl_pkg::NODE_W-1:0] mem [dwl_pkg::NODE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

// File: rtl/dwl_walker.sv
// dwl_walker: sequencer that loads nodes, walks sibling lists per letter and emits results.
// Depends on dwl_pkg and dwl_node_ram.
module dwl_walker (
	input  logic          clk,
	input  logic          arst_n,
	input  dwl_pkg::cfg_t cfg,
	input  logic          req_valid,
	output logic          req_stall,
	input  dwl_pkg::req_t req,
	output logic          push,
	input  logic          push_ready,
	output dwl_pkg::rsp_t push_data
);

	dwl_pkg::state_t state_q, state_d;

	logic [dwl_pkg::ADDR_W-1:0]  cur_q, cur_d;
	logic [dwl_pkg::ADDR_W-1:0]  n_q, n_d;
	logic [dwl_pkg::CHILD_W-1:0] child_q, child_d;
	logic [dwl_pkg::HCNT_W-1:0]  nh_q, nh_d;
	logic [7:0]                  root_q, root_d;
	logic [7:0]                  ch_q, ch_d;
	logic                        failed_q, failed_d;
	logic                        last_q, last_d;
	logic                        eow_q, eow_d;
	dwl_pkg::rsp_t               pend_q, pend_d;

	logic                        wr_en, rd_en;
	logic [dwl_pkg::ADDR_W-1:0]  rd_addr;
	logic [dwl_pkg::NODE_W-1:0]  rd_data;

	logic [4:0]                  rd_code;
	logic                        rd_eow, rd_eol, sib_end;
	logic [dwl_pkg::CHILD_W-1:0] rd_child;
	logic [7:0]                  rd_letter;
	logic [dwl_pkg::TOTAL_W-1:0] root_ext, root_diff;
	logic                        root_ok;
	logic                        hook_done;

	dwl_node_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (req.node_addr[dwl_pkg::ADDR_W-1:0]),
		.wr_data (req.node_word[dwl_pkg::NODE_W-1:0]),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign rd_code   = rd_data[4:0];
	assign rd_eow    = rd_data[5];
	assign rd_eol    = rd_data[6];
	assign rd_child  = rd_data[dwl_pkg::NODE_W-1:7];
	assign rd_letter = dwl_pkg::node_letter(rd_code);
	assign sib_end   = rd_eol || (n_q == '1);

	assign root_ext  = {{(dwl_pkg::TOTAL_W-8){1'b0}}, root_q};
	assign root_diff = cfg.node_total - root_ext;
	assign root_ok   = (cfg.node_total > root_ext) && !root_diff[dwl_pkg::TOTAL_W-1];
	assign hook_done = sib_end || (rd_eow && nh_q == dwl_pkg::HCNT_W'(dwl_pkg::MAX_HOOKS - 1));

	assign req_stall = (state_q != dwl_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dwl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q    <= '0;
			failed_q <= 1'b0;
			root_q   <= dwl_pkg::ROOT_MIN;
		end else begin
			cur_q    <= cur_d;
			failed_q <= failed_d;
			root_q   <= root_d;
		end
	end

	always_ff @(posedge clk) begin
		n_q     <= n_d;
		child_q <= child_d;
		nh_q    <= nh_d;
		ch_q    <= ch_d;
		last_q  <= last_d;
		eow_q   <= eow_d;
		pend_q  <= pend_d;
	end

	always_comb begin
		state_d   = state_q;
		cur_d     = cur_q;
		n_d       = n_q;
		child_d   = child_q;
		nh_d      = nh_q;
		root_d    = root_q;
		ch_d      = ch_q;
		failed_d  = failed_q;
		last_d    = last_q;
		eow_d     = eow_q;
		pend_d    = pend_q;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = n_q;
		push      = 1'b0;
		push_data = pend_q;
		case (state_q)
			dwl_pkg::ST_IDLE: begin
				if (req_valid) begin
					if (req.req_type == dwl_pkg::REQ_LOAD) begin
						if (req.node_addr == '0) begin
							if (req.node_word[7:0] < dwl_pkg::ROOT_MIN)
								root_d = dwl_pkg::ROOT_MIN;
							else
								root_d = req.node_word[7:0];
						end else begin
							wr_en = 1'b1;
						end
					end else begin
						ch_d   = dwl_pkg::fold_upper(req.query_char);
						last_d = req.query_last;
						if (failed_q) begin
							state_d = dwl_pkg::ST_AFTER;
						end else if (cur_q == '0) begin
							if (root_ok) begin
								n_d     = root_diff[dwl_pkg::ADDR_W-1:0];
								rd_en   = 1'b1;
								rd_addr = root_diff[dwl_pkg::ADDR_W-1:0];
								state_d = dwl_pkg::ST_CMP;
							end else begin
								failed_d = 1'b1;
								state_d  = dwl_pkg::ST_AFTER;
							end
						end else begin
							rd_en   = 1'b1;
							rd_addr = cur_q;
							state_d = dwl_pkg::ST_CHILD;
						end
					end
				end
			end
			dwl_pkg::ST_CHILD: begin
				if (rd_child == '0) begin
					failed_d = 1'b1;
					state_d  = dwl_pkg::ST_AFTER;
				end else begin
					n_d     = rd_child;
					rd_en   = 1'b1;
					rd_addr = rd_child;
					state_d = dwl_pkg::ST_CMP;
				end
			end
			dwl_pkg::ST_CMP: begin
				if (rd_letter != 8'd0 && rd_letter == ch_q) begin
					cur_d   = n_q;
					eow_d   = rd_eow;
					child_d = rd_child;
					state_d = dwl_pkg::ST_AFTER;
				end else if (sib_end) begin
					failed_d = 1'b1;
					state_d  = dwl_pkg::ST_AFTER;
				end else begin
					n_d     = n_q + 1'b1;
					rd_en   = 1'b1;
					rd_addr = n_q + 1'b1;
				end
			end
			dwl_pkg::ST_AFTER: begin
				if (!last_q) begin
					state_d = dwl_pkg::ST_IDLE;
				end else begin
					pend_d.result_kind  = dwl_pkg::RES_VERDICT;
					pend_d.word_found   = !failed_q && eow_q;
					pend_d.prefix_found = !failed_q;
					pend_d.end_node     = failed_q ? '0 : cur_q;
					pend_d.hook_char    = 8'd0;
					pend_d.last_result  = 1'b0;
					nh_d                = '0;
					if (!failed_q && cfg.hooks_enable && child_q != '0) begin
						n_d     = child_q;
						rd_en   = 1'b1;
						rd_addr = child_q;
						state_d = dwl_pkg::ST_HOOK;
					end else begin
						state_d = dwl_pkg::ST_FLUSH;
					end
				end
			end
			dwl_pkg::ST_HOOK: begin
				// a hook waits for room before the held result moves on
				if (!(rd_eow && !push_ready)) begin
					if (rd_eow) begin
						push                = 1'b1;
						pend_d.result_kind  = dwl_pkg::RES_HOOK;
						pend_d.word_found   = 1'b0;
						pend_d.prefix_found = 1'b0;
						pend_d.end_node     = '0;
						pend_d.hook_char    = rd_letter;
						pend_d.last_result  = 1'b0;
						nh_d                = nh_q + 1'b1;
					end
					if (hook_done) begin
						state_d = dwl_pkg::ST_FLUSH;
					end else begin
						n_d     = n_q + 1'b1;
						rd_en   = 1'b1;
						rd_addr = n_q + 1'b1;
					end
				end
			end
			dwl_pkg::ST_FLUSH: begin
				push_data.last_result = 1'b1;
				if (push_ready) begin
					push     = 1'b1;
					cur_d    = '0;
					failed_d = 1'b0;
					state_d  = dwl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dwl_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/dawg_word_lookup.sv
// dawg_word_lookup: top level of the word graph lookup, config registers and result register.
// Depends on dwl_pkg and dwl_walker.
//
// Usage. The req channel takes one word per handshake (req_valid high, req_stall low):
// a load word (req_type 0) writes node_word into the node store at node_addr, or at
// address 0 sets the root offset; a query word (req_type 1) carries one letter and
// query_last marks the final letter. The cfg channel writes node_total (index 0) and
// hooks_enable (index 1); cfg_ready is always high, write only while the block is idle.
// A load is written while the walker stays idle. A letter first reads the current node
// for its child pointer when the walk starts below the root, then scans the sibling
// list one node at a time through the read port of the node store, until a match or
// the end of the list. After the last letter the verdict is held while the hook list
// is scanned, and the verdict leaves first, then up to 32 hook letters.
// The results pass through the rsp register; while rsp_stall is high it holds its
// word and the scan pauses at the next hook. req_stall is high whenever a word is in
// progress. Reset clears the control state, config, rsp_valid and current node and sets
// the root offset (26); the node store is not cleared and must be loaded before use.
module dawg_word_lookup (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  dwl_pkg::req_t                   req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output dwl_pkg::rsp_t                   rsp,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dwl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dwl_pkg::TOTAL_W-1:0]     cfg_data
);

	dwl_pkg::cfg_t cfg_q;
	dwl_pkg::rsp_t rsp_q, push_data;
	logic          rsp_valid_q;
	logic          push, push_ready;

	assign cfg_ready  = 1'b1;
	assign push_ready = !rsp_valid_q || !rsp_stall;
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dwl_pkg::CFG_NODE_TOTAL: cfg_q.node_total <= cfg_data;
				dwl_pkg::CFG_HOOKS_EN:   cfg_q.hooks_enable <= cfg_data[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (push) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			rsp_q <= push_data;
	end

	dwl_walker u_walker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.push       (push),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

endmodule
